// ===== sv/mabs_pkg.sv =====
`timescale 1ns / 1ps

package mabs_pkg;

    localparam int SYMBOL_W = 2;
    localparam int PRICE_W  = 40;
    localparam int MARGIN_W = 24;
    localparam int FRAC_W   = 24;

    localparam logic [MARGIN_W-1:0] MARGIN_RESET = 24'd8389;

    // Quotient bits resolved per divider stage.
    localparam int DIV_BITS_PER_STAGE = 8;

    typedef logic [SYMBOL_W-1:0] t_symbol;
    typedef logic [PRICE_W-1:0]  t_price;
    typedef logic [MARGIN_W-1:0] t_margin;

    // Result flags that ride alongside the average through the divider.
    typedef struct packed {
        logic buy;
        logic window_full;
        logic in_range;
    } t_res_flags;

    typedef struct packed {
        logic   buy;
        logic   window_full;
        t_price average;
    } t_result;

endpackage

// ===== sv/mabs_in_if.sv =====
`timescale 1ns / 1ps

interface mabs_in_if import mabs_pkg::*; ();
    logic    valid;
    logic    ready;
    t_symbol symbol;
    t_price  price;

    modport source (output valid, output symbol, output price, input ready);
    modport sink (input valid, input symbol, input price, output ready);
endinterface

// ===== sv/mabs_out_if.sv =====
`timescale 1ns / 1ps

interface mabs_out_if import mabs_pkg::*; ();
    logic   valid;
    logic   ready;
    logic   buy;
    logic   window_full;
    t_price average;

    modport source (output valid, output buy, output window_full, output average, input ready);
    modport sink (input valid, input buy, input window_full, input average, output ready);
endinterface

// ===== sv/mabs_div.sv =====
`timescale 1ns / 1ps

// Pipelined restoring divider for a narrow divisor. Each stage resolves
// up to DIV_BITS_PER_STAGE quotient bits; one operation enters per cycle.
module mabs_div import mabs_pkg::*; #(
    parameter int DVD_W = 43,
    parameter int DVS_W = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DVS_W-1:0] i_divisor,
    input  t_res_flags       i_flags,
    output logic             o_valid,
    output logic [DVD_W-1:0] o_quot,
    output t_res_flags       o_flags
);

    localparam int STAGES = (DVD_W + DIV_BITS_PER_STAGE - 1) / DIV_BITS_PER_STAGE;

    logic             r_vld   [STAGES];
    logic [DVS_W-1:0] r_rem   [STAGES];
    logic [DVD_W-1:0] r_work  [STAGES];
    logic [DVS_W-1:0] r_dvs   [STAGES];
    t_res_flags       r_flags [STAGES];

    logic             n_vld   [STAGES];
    logic [DVS_W-1:0] n_rem   [STAGES];
    logic [DVD_W-1:0] n_work  [STAGES];
    logic [DVS_W-1:0] n_dvs   [STAGES];
    t_res_flags       n_flags [STAGES];

    for (genvar k = 0; k < STAGES; k++) begin : g_stage
        localparam int LEFT  = DVD_W - k * DIV_BITS_PER_STAGE;
        localparam int STEPS = (LEFT < DIV_BITS_PER_STAGE) ? LEFT : DIV_BITS_PER_STAGE;

        logic             src_vld;
        logic [DVS_W-1:0] src_rem;
        logic [DVD_W-1:0] src_work;
        logic [DVS_W-1:0] src_dvs;
        t_res_flags       src_flags;

        if (k == 0) begin : g_first
            assign src_vld   = i_valid;
            assign src_rem   = '0;
            assign src_work  = i_dividend;
            assign src_dvs   = i_divisor;
            assign src_flags = i_flags;
        end else begin : g_next
            assign src_vld   = r_vld[k-1];
            assign src_rem   = r_rem[k-1];
            assign src_work  = r_work[k-1];
            assign src_dvs   = r_dvs[k-1];
            assign src_flags = r_flags[k-1];
        end

        // The partial remainder stays below the divisor, so each step is a
        // compare and subtract on DVS_W+1 bits.
        always_comb begin
            logic [DVS_W:0]   trial;
            logic [DVS_W:0]   diff;
            logic [DVS_W-1:0] rem;
            logic [DVD_W-1:0] work;
            rem  = src_rem;
            work = src_work;
            for (int j = 0; j < STEPS; j++) begin
                trial = {rem, work[DVD_W-1]};
                diff  = trial - {1'b0, src_dvs};
                if (trial >= {1'b0, src_dvs}) begin
                    rem  = diff[DVS_W-1:0];
                    work = {work[DVD_W-2:0], 1'b1};
                end else begin
                    rem  = trial[DVS_W-1:0];
                    work = {work[DVD_W-2:0], 1'b0};
                end
            end
            n_vld[k]   = src_vld;
            n_rem[k]   = rem;
            n_work[k]  = work;
            n_dvs[k]   = src_dvs;
            n_flags[k] = src_flags;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < STAGES; k++) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else begin
                r_vld[k] <= n_vld[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < STAGES; k++) begin
            r_rem[k]   <= n_rem[k];
            r_work[k]  <= n_work[k];
            r_dvs[k]   <= n_dvs[k];
            r_flags[k] <= n_flags[k];
        end
    end

    assign o_valid = r_vld[STAGES-1];
    assign o_quot  = r_work[STAGES-1];
    assign o_flags = r_flags[STAGES-1];

endmodule

// ===== sv/moving_average_buy_signal_core.sv =====
// Moving-average breakout detector for a tick feed. Each input beat carries a
// symbol index and an unsigned price; each one produces exactly one output beat,
// in order, with the truncated average of that symbol's last (up to) WINDOW prices, a
// window-full flag, and a buy flag that is set when the window is full and
// price * WINDOW * 2^24 > sum * (2^24 + margin_q24). The margin register resets
// to 8389 (0.0005 in Q0.24) and may be rewritten through the config port while
// no beats are in flight. A symbol at or above NUM_SYMBOLS leaves all state
// alone and returns a beat of zeros. The block accepts one beat per clock,
// also on back-to-back ticks of the same symbol, as long as fewer than
// FIFO_DEPTH beats are accepted and not yet delivered; the output queue is
// sized so that a sink that is always ready never throttles the input. On its
// way to the output a beat passes the per-symbol read-modify-write (stages 1
// and 2), the margin multiply and compare (stages 3 and 4), the pipelined
// averaging divider and the output queue.
// Per-symbol state comes out of reset cleared at once, with no clearing pass.
`timescale 1ns / 1ps

module moving_average_buy_signal_core import mabs_pkg::*; #(
    parameter int WINDOW      = 8,
    parameter int NUM_SYMBOLS = 4
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_wr_en,
    input  t_margin   i_cfg_wr_data,
    mabs_in_if.sink   i_in,
    mabs_out_if.source o_out
);

    localparam int SLOT_W     = $clog2(WINDOW);
    localparam int CNT_W      = $clog2(WINDOW + 1);
    localparam int SYM_W      = (NUM_SYMBOLS > 1) ? $clog2(NUM_SYMBOLS) : 1;
    localparam int CTL_DEPTH  = 2 ** SYM_W;
    localparam int HIST_AW    = SYM_W + SLOT_W;
    localparam int HIST_DEPTH = 2 ** HIST_AW;
    localparam int SUM_W      = PRICE_W + $clog2(WINDOW);
    localparam int SUM_LO_W   = (SUM_W + 1) / 2;
    localparam int SUM_HI_W   = SUM_W - SUM_LO_W;
    localparam int PLO_W      = SUM_LO_W + MARGIN_W;
    localparam int PHI_W      = SUM_HI_W + MARGIN_W;
    localparam int PROD_W     = SUM_W + FRAC_W;
    localparam int DIV_STAGES = (SUM_W + DIV_BITS_PER_STAGE - 1) / DIV_BITS_PER_STAGE;
    localparam int PIPE_LAT   = 4 + DIV_STAGES;
    localparam int FIFO_AW    = $clog2(PIPE_LAT + 3);
    localparam int FIFO_DEPTH = 2 ** FIFO_AW;

    localparam logic [CNT_W-1:0]  WINDOW_CNT = CNT_W'(WINDOW);
    localparam logic [SLOT_W-1:0] LAST_SLOT  = SLOT_W'(WINDOW - 1);

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic [CNT_W-1:0]  cnt;
    } t_ctl;

    // Handshake and configuration.
    logic    in_acc;
    logic    out_acc;
    t_margin r_margin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_margin <= MARGIN_RESET;
        end else if (i_cfg_wr_en) begin
            r_margin <= i_cfg_wr_data;
        end
    end

    // Per-symbol state. The control word (write slot and fill count) and the
    // running sum live in small memories; r_seen marks symbols that have been
    // written since reset so that an untouched symbol reads as empty.
    t_ctl               r_ctl_mem  [CTL_DEPTH];
    logic [SUM_W-1:0]   r_sum_mem  [CTL_DEPTH];
    t_price             r_hist_mem [HIST_DEPTH];
    logic [CTL_DEPTH-1:0] r_seen;

    logic [SYM_W-1:0] in_sym;
    logic             in_range;

    assign in_sym   = SYM_W'(i_in.symbol);
    assign in_range = (32'(i_in.symbol) < NUM_SYMBOLS);

    // Stage 1: control word resolved, history slot read and overwritten.
    logic             r1_vld;
    logic             r1_in_range;
    logic [SYM_W-1:0] r1_sym;
    t_price           r1_price;
    t_ctl             r1_ctl_rd;
    logic             r1_seen;

    logic               fwd1;
    t_ctl               s1_old_ctl;
    t_ctl               s1_new_ctl;
    logic               s1_old_full;
    logic               s1_wr;
    logic [HIST_AW-1:0] s1_hist_addr;

    // Stage 2: running sum updated.
    logic             r2_vld;
    logic             r2_in_range;
    logic [SYM_W-1:0] r2_sym;
    t_price           r2_price;
    t_ctl             r2_ctl;
    logic             r2_evict_en;
    logic             r2_was_empty;
    t_price           r2_evict;
    logic [SUM_W-1:0] r2_sum_rd;

    logic             fwd2;
    logic             s2_wr;
    logic [SUM_W-1:0] s2_sum_old;
    logic [SUM_W-1:0] s2_sum_new;

    // Stage 3: price excess over the sum and margin partial products.
    logic             r3_vld;
    logic             r3_in_range;
    logic [SYM_W-1:0] r3_sym;
    t_price           r3_price;
    logic [SUM_W-1:0] r3_sum;
    logic [CNT_W-1:0] r3_cnt;
    logic             r3_full;

    logic [SUM_W-1:0] s3_wprice;
    logic [SUM_W:0]   s3_diff;
    logic [PLO_W-1:0] s3_p_lo;
    logic [PHI_W-1:0] s3_p_hi;

    // Stage 4: buy compare, then into the divider.
    logic             r4_vld;
    logic             r4_in_range;
    logic [SUM_W-1:0] r4_sum;
    logic [CNT_W-1:0] r4_cnt;
    logic             r4_full;
    logic             r4_pos;
    logic [SUM_W-1:0] r4_diff;
    logic [PLO_W-1:0] r4_p_lo;
    logic [PHI_W-1:0] r4_p_hi;

    logic [PROD_W-1:0] s4_prod;
    t_res_flags        s4_flags;

    logic             div_vld;
    logic [SUM_W-1:0] div_quot;
    t_res_flags       div_flags;

    // Output queue and credit count.
    t_result            r_fifo [FIFO_DEPTH];
    logic [FIFO_AW:0]   r_wr_ptr;
    logic [FIFO_AW:0]   r_rd_ptr;
    logic [FIFO_AW:0]   r_inflight;
    logic [FIFO_AW:0]   n_inflight;
    t_result            fifo_entry;
    t_result            rd_entry;

    // The input is throttled only by the credit count, which is a register,
    // so ready never depends on the sink in the same cycle.
    assign i_in.ready = (r_inflight < (FIFO_AW + 1)'(FIFO_DEPTH));
    assign in_acc     = i_in.valid & i_in.ready;

    // ------------------------------------------------------------------
    // Stage 1. The control memory was read at acceptance. If the beat just
    // ahead belongs to the same symbol, its write landed on the same edge as
    // our read, so its new control word is taken from stage 2 instead.
    // ------------------------------------------------------------------
    always_comb begin
        fwd1 = r2_vld & r2_in_range & (r2_sym == r1_sym);
        if (fwd1) begin
            s1_old_ctl = r2_ctl;
        end else if (r1_seen) begin
            s1_old_ctl = r1_ctl_rd;
        end else begin
            s1_old_ctl = '0;
        end
        s1_old_full = (s1_old_ctl.cnt == WINDOW_CNT);
        s1_new_ctl.cnt  = s1_old_full ? WINDOW_CNT : s1_old_ctl.cnt + CNT_W'(1);
        s1_new_ctl.slot = (s1_old_ctl.slot == LAST_SLOT) ? '0 :
                          s1_old_ctl.slot + SLOT_W'(1);
        s1_wr        = r1_vld & r1_in_range;
        s1_hist_addr = {r1_sym, s1_old_ctl.slot};
    end

    always_ff @(posedge i_clk) begin
        r1_ctl_rd <= r_ctl_mem[in_sym];
        if (s1_wr) begin
            r_ctl_mem[r1_sym] <= s1_new_ctl;
        end
    end

    // Read-before-write on the same slot: the evicted price comes out while
    // the new price goes in. The old entry is only used once the window is
    // full, so slots never written are never looked at.
    always_ff @(posedge i_clk) begin
        r2_evict <= r_hist_mem[s1_hist_addr];
        if (s1_wr) begin
            r_hist_mem[s1_hist_addr] <= r1_price;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= '0;
        end else if (s1_wr) begin
            r_seen[r1_sym] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_in_range  <= in_range;
        r1_sym       <= in_sym;
        r1_price     <= i_in.price;
        r1_seen      <= r_seen[in_sym];
        r2_in_range  <= r1_in_range;
        r2_sym       <= r1_sym;
        r2_price     <= r1_price;
        r2_ctl       <= s1_new_ctl;
        r2_evict_en  <= s1_old_full;
        r2_was_empty <= (s1_old_ctl.cnt == '0);
    end

    // ------------------------------------------------------------------
    // Stage 2. The sum memory is read as a beat enters this stage; a beat of
    // the same symbol one stage ahead writes on that same edge, so its sum is
    // forwarded from stage 3. An empty window always has a zero sum.
    // ------------------------------------------------------------------
    always_comb begin
        fwd2  = r3_vld & r3_in_range & (r3_sym == r2_sym);
        s2_wr = r2_vld & r2_in_range;
        if (r2_was_empty) begin
            s2_sum_old = '0;
        end else if (fwd2) begin
            s2_sum_old = r3_sum;
        end else begin
            s2_sum_old = r2_sum_rd;
        end
        s2_sum_new = s2_sum_old - (r2_evict_en ? SUM_W'(r2_evict) : '0) + SUM_W'(r2_price);
    end

    always_ff @(posedge i_clk) begin
        r2_sum_rd <= r_sum_mem[r1_sym];
        if (s2_wr) begin
            r_sum_mem[r2_sym] <= s2_sum_new;
        end
    end

    always_ff @(posedge i_clk) begin
        r3_in_range <= r2_in_range;
        r3_sym      <= r2_sym;
        r3_price    <= r2_price;
        r3_sum      <= s2_sum_new;
        r3_cnt      <= r2_ctl.cnt;
        r3_full     <= (r2_ctl.cnt == WINDOW_CNT);
    end

    // ------------------------------------------------------------------
    // Stage 3. The buy test price*W*2^24 > sum*2^24 + sum*margin is rewritten
    // as (price*W - sum)*2^24 > sum*margin. The product is split into two
    // narrow partial products so no multiplier exceeds 24 x 23 bits.
    // ------------------------------------------------------------------
    always_comb begin
        s3_wprice = SUM_W'(r3_price) * SUM_W'(WINDOW);
        s3_diff   = {1'b0, s3_wprice} - {1'b0, r3_sum};
        s3_p_lo   = PLO_W'(r3_sum[SUM_LO_W-1:0]) * PLO_W'(r_margin);
        s3_p_hi   = PHI_W'(r3_sum[SUM_W-1:SUM_LO_W]) * PHI_W'(r_margin);
    end

    always_ff @(posedge i_clk) begin
        r4_in_range <= r3_in_range;
        r4_sum      <= r3_sum;
        r4_cnt      <= r3_cnt;
        r4_full     <= r3_full;
        r4_pos      <= ~s3_diff[SUM_W] & (s3_diff[SUM_W-1:0] != '0);
        r4_diff     <= s3_diff[SUM_W-1:0];
        r4_p_lo     <= s3_p_lo;
        r4_p_hi     <= s3_p_hi;
    end

    // Stage 4. A non-positive excess can never beat a non-negative margin term.
    always_comb begin
        s4_prod = PROD_W'(r4_p_lo) + {r4_p_hi, SUM_LO_W'(0)};
        s4_flags.buy         = r4_full & r4_pos & ({r4_diff, FRAC_W'(0)} > s4_prod);
        s4_flags.window_full = r4_full;
        s4_flags.in_range    = r4_in_range;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
        end else begin
            r1_vld <= in_acc;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
            r4_vld <= r3_vld;
        end
    end

    // Average = sum / count. Out-of-range beats carry a meaningless count and
    // are zeroed when they reach the queue.
    mabs_div #(
        .DVD_W (SUM_W),
        .DVS_W (CNT_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (r4_vld),
        .i_dividend (r4_sum),
        .i_divisor  (r4_cnt),
        .i_flags    (s4_flags),
        .o_valid    (div_vld),
        .o_quot     (div_quot),
        .o_flags    (div_flags)
    );

    // ------------------------------------------------------------------
    // Output queue. The credit count guarantees it never overflows, so the
    // pipeline in front of it never stalls.
    // ------------------------------------------------------------------
    always_comb begin
        fifo_entry.buy         = div_flags.buy & div_flags.in_range;
        fifo_entry.window_full = div_flags.window_full & div_flags.in_range;
        fifo_entry.average     = div_flags.in_range ? div_quot[PRICE_W-1:0] : '0;
    end

    always_ff @(posedge i_clk) begin
        if (div_vld) begin
            r_fifo[r_wr_ptr[FIFO_AW-1:0]] <= fifo_entry;
        end
    end

    assign rd_entry          = r_fifo[r_rd_ptr[FIFO_AW-1:0]];
    assign o_out.valid       = (r_wr_ptr != r_rd_ptr);
    assign o_out.buy         = rd_entry.buy;
    assign o_out.window_full = rd_entry.window_full;
    assign o_out.average     = rd_entry.average;
    assign out_acc           = o_out.valid & o_out.ready;

    assign n_inflight = r_inflight + (FIFO_AW + 1)'(in_acc) - (FIFO_AW + 1)'(out_acc);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr   <= '0;
            r_rd_ptr   <= '0;
            r_inflight <= '0;
        end else begin
            if (div_vld) begin
                r_wr_ptr <= r_wr_ptr + (FIFO_AW + 1)'(1);
            end
            if (out_acc) begin
                r_rd_ptr <= r_rd_ptr + (FIFO_AW + 1)'(1);
            end
            r_inflight <= n_inflight;
        end
    end

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    a_credit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_inflight <= (FIFO_AW + 1)'(FIFO_DEPTH))
        else $error("more beats in flight than the output queue can hold");

    a_queue_within_credit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wr_ptr - r_rd_ptr) <= r_inflight)
        else $error("output queue holds beats that were never accepted");

    a_ctl_update_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_wr |-> (s1_new_ctl.cnt != '0) && (s1_new_ctl.cnt <= WINDOW_CNT) &&
                  (s1_new_ctl.slot <= LAST_SLOT))
        else $error("per-symbol control word out of range after update");

    a_fixed_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |-> ##(PIPE_LAT) div_vld)
        else $error("accepted beat did not reach the output queue on time");

endmodule

// ===== bench/moving_average_buy_signal_core_tb.sv =====
`timescale 1ns / 1ps

// Checks the moving-average buy signal core against its own window predictor.
// Every tick that the core accepts is run through the predictor at that
// moment. The predicted beat is queued. Every result beat that leaves the core
// is compared field by field with the oldest queued beat.
module moving_average_buy_signal_core_tb;
    import mabs_pkg::*;

    localparam int WINDOW      = 8;
    localparam int NUM_SYMBOLS = 4;

    // Idle time that wait_idle adds once every predicted beat has come back.
    localparam int SETTLE_CYCLES = 16;
    localparam int CYCLE_LIMIT   = 300000;

    localparam t_price  PRICE_MAX  = '1;
    localparam t_margin MARGIN_MAX = '1;

    // Leading term of the exact buy threshold's denominator: WINDOW - 1 in Q.24.
    localparam logic [79:0] WIN_LESS_ONE_Q24 = 80'(WINDOW - 1) << FRAC_W;

    typedef enum logic [1:0] {
        RX_ALWAYS,
        RX_RANDOM,
        RX_PATTERN
    } t_rx_mode;

    logic    i_clk;
    logic    i_rst_n;
    logic    i_cfg_wr_en;
    t_margin i_cfg_wr_data;

    mabs_in_if  tick_bus ();
    mabs_out_if result_bus ();

    moving_average_buy_signal_core #(
        .WINDOW      (WINDOW),
        .NUM_SYMBOLS (NUM_SYMBOLS)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in          (tick_bus),
        .o_out         (result_bus)
    );

    // Predictor state, one window per symbol, and its copy of the margin register.
    t_price      hist [NUM_SYMBOLS][WINDOW];
    logic [45:0] win_sum [NUM_SYMBOLS];
    int          win_count [NUM_SYMBOLS];
    int          win_slot [NUM_SYMBOLS];
    t_price      last_px [NUM_SYMBOLS];
    t_margin     margin_reg;
    t_symbol     last_sym;

    t_result expected_results[$];

    int err_count;
    int ticks_sent;
    int results_checked;
    int buys_seen;
    int full_seen;
    int margins_used;
    int cycle_count;

    // Sender burst control. When gaps_on is low the sender offers a tick every cycle.
    bit gaps_on;
    int burst_left;

    // Receiver control. A nonzero hold_req makes the receiver take it over as its own
    // hold-off count. Ready then stays low until that count runs out, whatever the mode.
    t_rx_mode   rx_mode;
    logic [7:0] rx_pattern;
    int         rx_phase;
    int         hold_req;
    int         hold_left;

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Pushes one tick through the predicted window and returns the beat it should
    // produce. The buy compare is done at full width, so it never truncates.
    function automatic t_result advance_window(input t_symbol sym, input t_price px);
        t_result     r;
        logic [79:0] lhs;
        logic [79:0] rhs;
        int          s;

        s = int'(sym);
        if (win_count[s] >= WINDOW) begin
            win_sum[s] = win_sum[s] - 46'(hist[s][win_slot[s]]);
        end else begin
            win_count[s]++;
        end
        hist[s][win_slot[s]] = px;
        win_sum[s]  = win_sum[s] + 46'(px);
        win_slot[s] = (win_slot[s] + 1) % WINDOW;
        last_px[s]  = px;

        r.window_full = (win_count[s] == WINDOW);
        r.average     = t_price'(win_sum[s] / 46'(win_count[s]));
        r.buy         = 1'b0;
        if (r.window_full) begin
            lhs   = (80'(px) * 80'(WINDOW)) << FRAC_W;
            rhs   = 80'(win_sum[s]) * 80'({1'b1, margin_reg});
            r.buy = (lhs > rhs);
        end
        return r;
    endfunction

    // Chooses a price that lands within two units of the exact buy threshold. The
    // threshold takes into account the price that this tick itself evicts and adds.
    function automatic t_price threshold_price(input t_symbol sym);
        logic [45:0] base;
        logic [79:0] q;
        int          s;

        s    = int'(sym);
        base = win_sum[s];
        if (win_count[s] >= WINDOW) begin
            base = base - 46'(hist[s][win_slot[s]]);
        end
        q = (80'(base) * 80'({1'b1, margin_reg})) / (WIN_LESS_ONE_Q24 - 80'(margin_reg));
        q = q + 80'($urandom_range(0, 4));
        q = (q >= 80'd2) ? q - 80'd2 : 80'd0;
        if (q > 80'(PRICE_MAX)) begin
            q = 80'(PRICE_MAX);
        end
        return t_price'(q);
    endfunction

    // Random walk from the symbol's last price. The step scales with the price.
    function automatic t_price walk_price(input t_symbol sym);
        logic [41:0] p;
        logic [41:0] span;

        span = 42'(last_px[int'(sym)] >> 4) + 42'd8;
        if (span > 42'd1000000) begin
            span = 42'd1000000;
        end
        p = 42'(last_px[int'(sym)]) + 42'($urandom_range(0, 2 * int'(span)));
        p = (p >= span) ? p - span : 42'd0;
        if (p > 42'(PRICE_MAX)) begin
            p = 42'(PRICE_MAX);
        end
        return t_price'(p);
    endfunction

    function automatic t_price pick_price(input t_symbol sym);
        int r;

        r = $urandom_range(0, 99);
        if (r < 40) begin
            // Only a tick that fills or slides the window can buy, so the threshold is
            // aimed at only once the window holds at least WINDOW - 1 prices.
            if (win_count[int'(sym)] >= WINDOW - 1) begin
                return threshold_price(sym);
            end
            return walk_price(sym);
        end else if (r < 65) begin
            return walk_price(sym);
        end else if (r < 85) begin
            return {8'($urandom_range(0, 255)), 32'($urandom())};
        end else if (r < 95) begin
            return ($urandom_range(0, 1) != 0) ? PRICE_MAX : '0;
        end
        return t_price'($urandom_range(0, 15));
    endfunction

    // At least half of the ticks repeat the last symbol. Back-to-back ticks of the same
    // symbol exercise the read-modify-write forwarding in the core.
    function automatic t_symbol pick_symbol();
        if ($urandom_range(0, 1) != 0) begin
            return last_sym;
        end
        last_sym = t_symbol'($urandom_range(0, NUM_SYMBOLS - 1));
        return last_sym;
    endfunction

    // Sends one tick. It is entered and left at a falling edge. When valid is to stay
    // high for the next tick it is not lowered in between, so no step sees it change
    // twice. The prediction is made at the rising edge that accepts the beat.
    task automatic send_tick(input t_symbol sym, input t_price px);
        t_result due;
        int      gap;

        if (gaps_on) begin
            if (burst_left == 0) begin
                gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30)
                                                  : $urandom_range(1, 5);
                burst_left = $urandom_range(1, 12);
                tick_bus.valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left--;
        end
        tick_bus.valid  <= 1'b1;
        tick_bus.symbol <= sym;
        tick_bus.price  <= px;
        @(posedge i_clk);
        while (!tick_bus.ready) begin
            @(posedge i_clk);
        end
        due = advance_window(sym, px);
        expected_results = {expected_results, due};
        ticks_sent++;
        @(negedge i_clk);
    endtask

    // Drops valid and waits until every predicted beat has come back, then lets the
    // pipeline settle. The cycle limit bounds the wait.
    task automatic wait_idle();
        tick_bus.valid <= 1'b0;
        while (expected_results.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_margin(input t_margin m);
        wait_idle();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= m;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        margin_reg = m;
        margins_used++;
    endtask

    task automatic run_random_ticks(input int n);
        t_symbol sym;

        repeat (n) begin
            sym = pick_symbol();
            send_tick(sym, pick_price(sym));
        end
    endtask

    // Window fill at the reset margin. Eight maximum prices fill symbol 3. The ninth
    // slides the window. A full window of equal prices must not buy, and the
    // largest sum checks the width of the accumulator. Symbol 0 holds only zeros.
    task automatic test_window_fill();
        gaps_on = 1'b0;
        rx_mode = RX_ALWAYS;
        repeat (WINDOW + 1) send_tick(t_symbol'(3), PRICE_MAX);
        send_tick(t_symbol'(0), '0);
        send_tick(t_symbol'(0), '0);
        wait_idle();
    endtask

    // Margin extremes. With a zero margin, a window of equal prices sits exactly on
    // the threshold and must not buy. One unit more must buy. With the largest
    // margin, a maximum price still buys and a zero price does not.
    task automatic test_margin_edges();
        write_margin('0);
        repeat (WINDOW) send_tick(t_symbol'(1), t_price'(1000));
        send_tick(t_symbol'(1), t_price'(1001));
        write_margin(MARGIN_MAX);
        send_tick(t_symbol'(1), PRICE_MAX);
        send_tick(t_symbol'(1), '0);
        wait_idle();
    endtask

    // Random ticks at the reset margin. The sender runs in bursts and the receiver
    // stalls at random.
    task automatic test_random_reset_margin();
        write_margin(MARGIN_RESET);
        gaps_on = 1'b1;
        rx_mode = RX_RANDOM;
        run_random_ticks(300);
        wait_idle();
    endtask

    // Largest margin at full rate, with no idling on either side.
    task automatic test_random_full_rate();
        write_margin(MARGIN_MAX);
        gaps_on = 1'b0;
        rx_mode = RX_ALWAYS;
        run_random_ticks(200);
        wait_idle();
    endtask

    // Zero margin. The receiver stalls on a fixed, rotating pattern.
    task automatic test_random_pattern_stall();
        write_margin('0);
        gaps_on    = 1'b1;
        rx_pattern = 8'b1011_0110;
        rx_mode    = RX_PATTERN;
        run_random_ticks(200);
        wait_idle();
    endtask

    // The receiver holds off for a long stretch while the sender offers a tick every
    // cycle. The output queue fills and the core has to stall its input.
    task automatic test_output_backpressure();
        write_margin(t_margin'($urandom_range(1, 65535)));
        gaps_on  = 1'b0;
        rx_mode  = RX_RANDOM;
        hold_req = 400;
        run_random_ticks(150);
        wait_idle();
    endtask

    // Mixed phases with random margins, bursty sender and random stalls.
    task automatic test_random_mixed();
        repeat (3) begin
            write_margin(t_margin'({$urandom()}));
            gaps_on = ($urandom_range(0, 3) != 0);
            rx_mode = ($urandom_range(0, 1) != 0) ? RX_RANDOM : RX_PATTERN;
            rx_pattern = 8'($urandom_range(1, 255));
            run_random_ticks(100);
        end
        wait_idle();
    endtask

    // Receiver. Ready changes only at the falling edge.
    always @(negedge i_clk) begin
        if (hold_req > 0) begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            result_bus.ready <= 1'b0;
        end else begin
            case (rx_mode)
                RX_ALWAYS: begin
                    result_bus.ready <= 1'b1;
                end
                RX_RANDOM: begin
                    result_bus.ready <= ($urandom_range(0, 3) != 0);
                end
                default: begin
                    result_bus.ready <= rx_pattern[rx_phase % 8];
                    rx_phase++;
                end
            endcase
        end
    end

    // Result checker. Each delivered beat is compared with the oldest predicted beat.
    always @(posedge i_clk) begin : check_results
        t_result want;

        if (i_rst_n && result_bus.valid && result_bus.ready) begin
            results_checked++;
            if (result_bus.buy) begin
                buys_seen++;
            end
            if (result_bus.window_full) begin
                full_seen++;
            end
            if (expected_results.size() == 0) begin
                $error("result beat with no tick outstanding: buy=%0b full=%0b avg=%0d",
                       result_bus.buy, result_bus.window_full, result_bus.average);
                err_count++;
            end else begin
                want = expected_results[0];
                expected_results.delete(0);
                if (result_bus.buy !== want.buy) begin
                    $error("buy: expected %0b, got %0b", want.buy, result_bus.buy);
                    err_count++;
                end
                if (result_bus.window_full !== want.window_full) begin
                    $error("window_full: expected %0b, got %0b",
                           want.window_full, result_bus.window_full);
                    err_count++;
                end
                if (result_bus.average !== want.average) begin
                    $error("average: expected %0d, got %0d", want.average, result_bus.average);
                    err_count++;
                end
            end
        end
    end

    initial begin
        // Every input is known from time zero. Reset is held low, then released at a falling edge.
        i_rst_n           = 1'b0;
        i_cfg_wr_en       = 1'b0;
        i_cfg_wr_data     = '0;
        tick_bus.valid    = 1'b0;
        tick_bus.symbol   = '0;
        tick_bus.price    = '0;
        result_bus.ready  = 1'b0;
        margin_reg        = MARGIN_RESET;
        last_sym          = '0;
        gaps_on           = 1'b0;
        burst_left        = 0;
        rx_mode           = RX_ALWAYS;
        rx_pattern        = 8'hFF;
        rx_phase          = 0;
        hold_req          = 0;
        hold_left         = 0;
        err_count         = 0;
        ticks_sent        = 0;
        results_checked   = 0;
        buys_seen         = 0;
        full_seen         = 0;
        margins_used      = 0;
        cycle_count       = 0;
        for (int s = 0; s < NUM_SYMBOLS; s++) begin
            win_sum[s]   = '0;
            win_count[s] = 0;
            win_slot[s]  = 0;
            last_px[s]   = t_price'(1000000);
        end

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_window_fill();
        test_margin_edges();
        test_random_reset_margin();
        test_random_full_rate();
        test_random_pattern_stall();
        test_output_backpressure();
        test_random_mixed();

        wait_idle();
        $display("Covered %0d ticks on %0d symbols under %0d margin settings;",
                 ticks_sent, NUM_SYMBOLS, margins_used + 1);
        $display("checked %0d result beats, %0d with a full window and %0d buys.",
                 results_checked, full_seen, buys_seen);
        if (err_count == 0 && expected_results.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
